// ===== rtl/core/grid_min_cost_path_unit_macros.svh =====
// ----------------------------------------------------------------------------
// grid_min_cost_path_unit assertion macros
// Shared concurrent assertion forms for the grid path unit.
// ----------------------------------------------------------------------------
`ifndef GRID_MIN_COST_PATH_UNIT_MACROS_SVH
`define GRID_MIN_COST_PATH_UNIT_MACROS_SVH

// Plain property, checked every cycle out of reset.
`define GMCP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define GMCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gmcp_pkg.sv =====
// ----------------------------------------------------------------------------
// gmcp_pkg
// Types and constants shared by the grid min cost path unit.
// ----------------------------------------------------------------------------
package gmcp_pkg;

  localparam int unsigned MaxCols  = 256;
  localparam int unsigned MaxRows  = 256;
  localparam int unsigned ColW     = $clog2(MaxCols);
  localparam int unsigned RowW     = $clog2(MaxRows);
  localparam int unsigned DimW     = 9;
  localparam int unsigned CostW    = 30;
  localparam int unsigned StepW    = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CostW-1:0] UnreachCost = CostW'(1000000000);

  localparam logic [KindW-1:0] KindPlain = 2'd0;
  localparam logic [KindW-1:0] KindSlow  = 2'd1;
  localparam logic [KindW-1:0] KindWall  = 2'd2;
  localparam logic [KindW-1:0] KindOther = 2'd3;

  localparam logic [CfgIdxW-1:0] RegGridRows = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGridCols = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCostSlow = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCostPlain = 2'd3;

  // One line buffer entry: a cell's best cost, kind and reach bit.
  typedef struct packed {
    logic             reach;
    logic [KindW-1:0] kind;
    logic [CostW-1:0] cost;
  } gmcp_cell_t;

  // Control of the item in the update stage.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             has_left;
    logic             has_above;
    logic             last;
    logic [ColW-1:0]  col;
    logic [KindW-1:0] kind;
  } gmcp_ctrl_t;

  typedef struct packed {
    logic [CostW-1:0] path_cost;
    logic             reachable;
  } gmcp_res_t;

endpackage

// ===== rtl/core/gmcp_line_buf.sv =====
// ----------------------------------------------------------------------------
// gmcp_line_buf
// One-row line buffer, one write and one registered read per cycle,
// write data forwarded on a same-address collision.
// ----------------------------------------------------------------------------
module gmcp_line_buf (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [gmcp_pkg::ColW-1:0] rd_addr_i,
  output gmcp_pkg::gmcp_cell_t   rd_data_o,
  input  logic                   wr_en_i,
  input  logic [gmcp_pkg::ColW-1:0] wr_addr_i,
  input  gmcp_pkg::gmcp_cell_t   wr_data_i
);
  import gmcp_pkg::*;

  gmcp_cell_t mem [MaxCols];
  gmcp_cell_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/gmcp_cell_upd.sv =====
// ----------------------------------------------------------------------------
// gmcp_cell_upd
// Cell recurrence: best of left and above neighbor plus the exit step cost.
// Holds the left neighbor state.
// ----------------------------------------------------------------------------
module gmcp_cell_upd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gmcp_pkg::gmcp_ctrl_t          ctrl_i,
  input  gmcp_pkg::gmcp_cell_t          above_i,
  input  logic [gmcp_pkg::StepW-1:0]    cost_slow_i,
  input  logic [gmcp_pkg::StepW-1:0]    cost_plain_i,
  output gmcp_pkg::gmcp_cell_t          cell_o
);
  import gmcp_pkg::*;

  gmcp_cell_t left_q;

  logic             left_ok;
  logic             above_ok;
  logic [StepW-1:0] left_step;
  logic [StepW-1:0] above_step;
  logic [CostW:0]   left_cand;
  logic [CostW:0]   above_cand;
  logic [CostW:0]   best;

  always_comb begin
    left_step  = (left_q.kind == KindSlow) ? cost_slow_i : cost_plain_i;
    above_step = (above_i.kind == KindSlow) ? cost_slow_i : cost_plain_i;
    left_cand  = {1'b0, left_q.cost} + {{(CostW+1-StepW){1'b0}}, left_step};
    above_cand = {1'b0, above_i.cost} + {{(CostW+1-StepW){1'b0}}, above_step};
    left_ok    = ctrl_i.has_left && left_q.reach &&
                 ((left_q.kind == KindPlain) || (left_q.kind == KindSlow));
    above_ok   = ctrl_i.has_above && above_i.reach &&
                 ((above_i.kind == KindPlain) || (above_i.kind == KindSlow));
    if (ctrl_i.kind == KindWall) begin
      left_ok  = 1'b0;
      above_ok = 1'b0;
    end
    if (left_ok && above_ok) begin
      best = (above_cand < left_cand) ? above_cand : left_cand;
    end else if (above_ok) begin
      best = above_cand;
    end else begin
      best = left_cand;
    end
    cell_o.kind = ctrl_i.kind;
    if (ctrl_i.first) begin
      cell_o.reach = 1'b1;
      cell_o.cost  = '0;
    end else if (left_ok || above_ok) begin
      cell_o.reach = 1'b1;
      cell_o.cost  = best[CostW-1:0];
    end else begin
      cell_o.reach = 1'b0;
      cell_o.cost  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (ctrl_i.valid) begin
      left_q <= cell_o;
    end
  end

endmodule

// ===== rtl/core/gmcp_res_fifo.sv =====
// ----------------------------------------------------------------------------
// gmcp_res_fifo
// Three-entry result queue between the update stage and the output channel.
// ----------------------------------------------------------------------------
module gmcp_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gmcp_pkg::gmcp_res_t push_data_i,
  output logic                valid_o,
  input  logic                stall_i,
  output gmcp_pkg::gmcp_res_t data_o,
  output logic [1:0]          count_o
);
  import gmcp_pkg::*;

  gmcp_res_t  entry_q [3];
  logic [1:0] wr_ptr_q;
  logic [1:0] rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       pop;

  function automatic logic [1:0] ptr_inc(input logic [1:0] ptr);
    return (ptr == 2'd2) ? 2'd0 : ptr + 2'd1;
  endfunction

  assign valid_o = (count_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
    end
  end

endmodule

// ===== rtl/core/grid_min_cost_path_unit.sv =====
// ----------------------------------------------------------------------------
// grid_min_cost_path_unit
// Least right/down path cost over a grid streamed one cell per item in
// raster order, using a one-row line buffer.
//
//   channel  direction  handshake                data
//   in       in         in_valid_i / in_stall_o   cell_kind_i
//   out      out        out_valid_o / out_stall_i path_cost_o, reachable_o
//   cfg      in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One cell per cycle sustained while out_stall_i is low, also when every cell
// ends a grid. The above entry is read at accept and the cell is written back
// in the following cycle. The result of the last cell enters a three-entry
// queue at that same edge and is offered on the output from that edge on.
// in_stall_o rises only when that queue could overflow.
// Reset clears counters, left state and queue; the line buffer is not cleared.
// ----------------------------------------------------------------------------
`include "grid_min_cost_path_unit_macros.svh"

module grid_min_cost_path_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gmcp_pkg::KindW-1:0]     cell_kind_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gmcp_pkg::CostW-1:0]     path_cost_o,
  output logic                           reachable_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gmcp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gmcp_pkg::DimW-1:0]      cfg_data_i
);
  import gmcp_pkg::*;

  logic [DimW-1:0]  rows_q;
  logic [DimW-1:0]  cols_q;
  logic [StepW-1:0] cost_slow_q;
  logic [StepW-1:0] cost_plain_q;
  logic [DimW-1:0]  dim_clamped;

  logic [ColW-1:0]  col_q;
  logic [ColW-1:0]  col_d;
  logic [RowW-1:0]  row_q;
  logic [RowW-1:0]  row_d;
  gmcp_ctrl_t       ctrl_q;
  gmcp_ctrl_t       ctrl_d;

  logic             accept;
  logic             row_end;
  logic             grid_end;
  gmcp_cell_t       above;
  gmcp_cell_t       upd_cell;
  gmcp_res_t        res;
  gmcp_res_t        res_out;
  logic [1:0]       res_cnt;
  logic             res_push;
  logic             res_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign res_push    = ctrl_q.valid && ctrl_q.last;
  assign res_pop     = out_valid_o && !out_stall_i;
  assign in_stall_o  = ({1'b0, res_cnt} + {2'b00, res_push}) >= 3'd3;

  always_comb begin
    if (cfg_data_i == '0) begin
      dim_clamped = DimW'(1);
    end else if (cfg_data_i > DimW'(MaxCols)) begin
      dim_clamped = DimW'(MaxCols);
    end else begin
      dim_clamped = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q       <= DimW'(1);
      cols_q       <= DimW'(1);
      cost_slow_q  <= StepW'(5);
      cost_plain_q <= StepW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegGridRows:  rows_q       <= (dim_clamped > DimW'(MaxRows)) ?
                                      DimW'(MaxRows) : dim_clamped;
        RegGridCols:  cols_q       <= dim_clamped;
        RegCostSlow:  cost_slow_q  <= cfg_data_i[StepW-1:0];
        RegCostPlain: cost_plain_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    row_end  = ({1'b0, col_q} + DimW'(1)) >= cols_q;
    grid_end = row_end && (({1'b0, row_q} + DimW'(1)) >= rows_q);
    col_d    = row_end ? '0 : col_q + ColW'(1);
    row_d    = grid_end ? '0 : (row_end ? row_q + RowW'(1) : row_q);
    ctrl_d.valid     = accept;
    ctrl_d.first     = (row_q == '0) && (col_q == '0);
    ctrl_d.has_left  = (col_q != '0);
    ctrl_d.has_above = (row_q != '0);
    ctrl_d.last      = grid_end;
    ctrl_d.col       = col_q;
    ctrl_d.kind      = cell_kind_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  gmcp_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (above),
    .wr_en_i   (ctrl_q.valid),
    .wr_addr_i (ctrl_q.col),
    .wr_data_i (upd_cell)
  );

  gmcp_cell_upd u_cell_upd (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_q),
    .above_i      (above),
    .cost_slow_i  (cost_slow_q),
    .cost_plain_i (cost_plain_q),
    .cell_o       (upd_cell)
  );

  assign res.path_cost = upd_cell.reach ? upd_cell.cost : UnreachCost;
  assign res.reachable = upd_cell.reach;

  gmcp_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .data_o      (res_out),
    .count_o     (res_cnt)
  );

  assign path_cost_o = res_out.path_cost;
  assign reachable_o = res_out.reachable;

  `GMCP_ASSERT(a_full_stalls, clk_i, rst_ni, (res_cnt != 2'd3) || in_stall_o, "full queue not stalling")
  `GMCP_ASSERT(a_no_overflow, clk_i, rst_ni, !res_push || (res_cnt != 2'd3) || res_pop, "queue overflow")
  `GMCP_ASSERT_NEXT(a_accept_stage, clk_i, rst_ni, accept, ctrl_q.valid && (ctrl_q.col == $past(col_q)), "accepted item missing from update stage")

endmodule
